/* hdl/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, character codes and verdict codes shared by the address text
// classifier and its IPv4 and IPv6 group checkers.
// ----------------------------------------------------------------------------
package ipc_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       has_char;
		logic       end_of_string;
	} item_t;

	localparam logic [1:0] VERDICT_V4   = 2'd0;
	localparam logic [1:0] VERDICT_V6   = 2'd1;
	localparam logic [1:0] VERDICT_NONE = 2'd2;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;

	localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
	localparam logic [9:0] V4_SAT_VALUE  = 10'd1023;
	localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
	localparam logic [2:0] V4_LAST_GROUP = 3'd3;
	localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
	localparam logic [3:0] V6_LAST_GROUP = 4'd7;
	localparam logic [2:0] DIGIT_SAT     = 3'd7;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CHAR_0) && (c <= CHAR_9);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CHAR_LA) && (c <= CHAR_LF)) ||
			((c >= CHAR_UA) && (c <= CHAR_UF));
	endfunction

endpackage

/* hdl/ipc_v4_check.sv */
// ----------------------------------------------------------------------------
// ipc_v4_check
// IPv4 group tracker: holds the dotted-decimal state and reports whether the
// string ending with the current transaction is a valid IPv4 address.
// ----------------------------------------------------------------------------
module ipc_v4_check
	import ipc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output logic  final_ok
);

	logic       alive_q;
	logic [2:0] group_count_q;
	logic [2:0] digit_count_q;
	logic [9:0] group_value_q;
	logic       first_zero_q;

	logic       alive_n;
	logic [2:0] group_count_n;
	logic [2:0] digit_count_n;
	logic [9:0] group_value_n;
	logic       first_zero_n;
	logic [13:0] product;
	logic       cur_ok;
	logic       next_ok;

	assign product = {4'd0, group_value_q} * 14'd10 + {10'd0, item.character[3:0]};

	assign cur_ok = (digit_count_q != 3'd0) && (digit_count_q <= V4_MAX_DIGITS) &&
		!(first_zero_q && (digit_count_q > 3'd1)) && (group_value_q <= V4_MAX_VALUE);

	always_comb begin
		alive_n       = alive_q;
		group_count_n = group_count_q;
		digit_count_n = digit_count_q;
		group_value_n = group_value_q;
		first_zero_n  = first_zero_q;
		if (item.has_char) begin
			if (is_dec(item.character)) begin
				if (digit_count_q == 3'd0)
					first_zero_n = (item.character == CHAR_0);
				group_value_n = (product > {4'd0, V4_SAT_VALUE}) ? V4_SAT_VALUE
					: product[9:0];
				if (digit_count_q < DIGIT_SAT)
					digit_count_n = digit_count_q + 3'd1;
			end else if (item.character == CHAR_DOT) begin
				if (!cur_ok || (group_count_q >= V4_LAST_GROUP))
					alive_n = 1'b0;
				else
					group_count_n = group_count_q + 3'd1;
				digit_count_n = 3'd0;
				group_value_n = 10'd0;
				first_zero_n  = 1'b0;
			end else begin
				alive_n = 1'b0;
			end
		end
	end

	assign next_ok = (digit_count_n != 3'd0) && (digit_count_n <= V4_MAX_DIGITS) &&
		!(first_zero_n && (digit_count_n > 3'd1)) && (group_value_n <= V4_MAX_VALUE);

	assign final_ok = alive_n && next_ok && (group_count_n == V4_LAST_GROUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q       <= 1'b1;
			group_count_q <= 3'd0;
			digit_count_q <= 3'd0;
			group_value_q <= 10'd0;
			first_zero_q  <= 1'b0;
		end else if (step) begin
			if (item.end_of_string) begin
				alive_q       <= 1'b1;
				group_count_q <= 3'd0;
				digit_count_q <= 3'd0;
				group_value_q <= 10'd0;
				first_zero_q  <= 1'b0;
			end else begin
				alive_q       <= alive_n;
				group_count_q <= group_count_n;
				digit_count_q <= digit_count_n;
				group_value_q <= group_value_n;
				first_zero_q  <= first_zero_n;
			end
		end
	end

endmodule

/* hdl/ipc_v6_check.sv */
// ----------------------------------------------------------------------------
// ipc_v6_check
// IPv6 group tracker: holds the colon-hex state and reports whether the
// string ending with the current transaction is a valid full IPv6 address.
// ----------------------------------------------------------------------------
module ipc_v6_check
	import ipc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output logic  final_ok
);

	logic       alive_q;
	logic [3:0] group_count_q;
	logic [2:0] digit_count_q;

	logic       alive_n;
	logic [3:0] group_count_n;
	logic [2:0] digit_count_n;
	logic       cur_ok;

	assign cur_ok = (digit_count_q != 3'd0) && (digit_count_q <= V6_MAX_DIGITS);

	always_comb begin
		alive_n       = alive_q;
		group_count_n = group_count_q;
		digit_count_n = digit_count_q;
		if (item.has_char) begin
			if (is_hex(item.character)) begin
				if (digit_count_q < DIGIT_SAT)
					digit_count_n = digit_count_q + 3'd1;
			end else if (item.character == CHAR_COLON) begin
				if (!cur_ok || (group_count_q >= V6_LAST_GROUP))
					alive_n = 1'b0;
				else
					group_count_n = group_count_q + 4'd1;
				digit_count_n = 3'd0;
			end else begin
				alive_n = 1'b0;
			end
		end
	end

	assign final_ok = alive_n && (digit_count_n != 3'd0) &&
		(digit_count_n <= V6_MAX_DIGITS) && (group_count_n == V6_LAST_GROUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q       <= 1'b1;
			group_count_q <= 4'd0;
			digit_count_q <= 3'd0;
		end else if (step) begin
			if (item.end_of_string) begin
				alive_q       <= 1'b1;
				group_count_q <= 4'd0;
				digit_count_q <= 3'd0;
			end else begin
				alive_q       <= alive_n;
				group_count_q <= group_count_n;
				digit_count_q <= digit_count_n;
			end
		end
	end

endmodule

/* hdl/ip_address_text_classifier.sv */
// A verdict appears on m_tvalid once the transaction that ends the string has
// passed through the input register and then the result register.
// Throughput: one character per cycle unless an end transaction waits; the state update is one pass of logic.
// An end transaction waits in the input register only while the result
// register still holds an untaken verdict.
// Reset (arst_n low) clears the valid bits of both registers and returns all checks to idle.
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Streams address text a byte at a time and classifies each string as IPv4,
// IPv6 or neither when the end marker arrives.
// ----------------------------------------------------------------------------
module ip_address_text_classifier
	import ipc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] character
	input  logic       s_tuser,   // [0] has_char
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);

	logic       valid_s1;
	item_t      item_s1;
	logic       dot_seen_q;
	logic       m_valid_q;
	logic [1:0] verdict_q;

	logic       out_free;
	logic       advance;
	logic       dot_next;
	logic       v4_ok;
	logic       v6_ok;
	logic [1:0] verdict;

	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && (!item_s1.end_of_string || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.character     <= s_tdata;
			item_s1.has_char      <= s_tuser;
			item_s1.end_of_string <= s_tlast;
		end
	end

	ipc_v4_check u_v4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.final_ok (v4_ok)
	);

	ipc_v6_check u_v6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.final_ok (v6_ok)
	);

	assign dot_next = dot_seen_q || (item_s1.has_char && (item_s1.character == CHAR_DOT));

	// any dot hands the decision to the IPv4 check
	always_comb begin
		if (dot_next)
			verdict = v4_ok ? VERDICT_V4 : VERDICT_NONE;
		else
			verdict = v6_ok ? VERDICT_V6 : VERDICT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_seen_q <= 1'b0;
		end else if (advance) begin
			dot_seen_q <= item_s1.end_of_string ? 1'b0 : dot_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_string) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_string)
			verdict_q <= verdict;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, verdict_q};

endmodule
